>>> src/cprc_pkg.sv
// ----------------------------------------------------------------------------
// cprc_pkg
// Shared types and constants for the capture packet RTPS classifier.
// ----------------------------------------------------------------------------
package cprc_pkg;

	// widths of the byte counter and the packet counters
	localparam int POSITION_BITS = 16;
	localparam int COUNT_BITS    = 32;

	// decoupling queue between parser and result stage
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// link type codes
	localparam logic [2:0] LINK_ETHERNET = 3'd0;
	localparam logic [2:0] LINK_NULL     = 3'd1;
	localparam logic [2:0] LINK_LOOP     = 3'd2;
	localparam logic [2:0] LINK_COOKED1  = 3'd3;
	localparam logic [2:0] LINK_COOKED2  = 3'd4;
	localparam logic [2:0] LINK_RAW      = 3'd5;

	// verdict codes
	localparam logic [2:0] VERDICT_RTPS     = 3'd0;
	localparam logic [2:0] VERDICT_LEN_MISM = 3'd1;
	localparam logic [2:0] VERDICT_NOT_IPV4 = 3'd2;
	localparam logic [2:0] VERDICT_NOT_UDP  = 3'd3;
	localparam logic [2:0] VERDICT_FRAG     = 3'd4;
	localparam logic [2:0] VERDICT_NOT_RTPS = 3'd5;

	// header constants
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  UDP_PROTO      = 8'd17;
	localparam logic [15:0] MORE_FRAGS     = 16'h2000;
	localparam logic [15:0] FRAG_OFFSET    = 16'h1fff;
	localparam int          IP_MIN_LEN     = 20;
	localparam int          UDP_HDR_LEN    = 8;

	localparam logic [7:0] RTPS_MAGIC [4] = '{8'h52, 8'h54, 8'h50, 8'h53};

	// per-packet summary handed from parser to result stage
	typedef struct packed {
		logic        mismatch;
		logic        link_ok;
		logic        too_short;
		logic        ver_ok;
		logic [7:0]  proto;
		logic [15:0] frag;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] offset;
		logic [15:0] udp_len;
		logic        magic_done;
	} cprc_rec_t;

	// link header length for a link type
	function automatic logic [4:0] link_len(input logic [2:0] lt);
		logic [4:0] l;
		case (lt)
			LINK_ETHERNET: l = 5'd14;
			LINK_NULL:     l = 5'd4;
			LINK_LOOP:     l = 5'd4;
			LINK_COOKED1:  l = 5'd16;
			LINK_COOKED2:  l = 5'd20;
			default:       l = 5'd0;
		endcase
		return l;
	endfunction

endpackage

>>> src/cprc_front.sv
// ----------------------------------------------------------------------------
// cprc_front
// Byte parser: walks link, IPv4 and UDP headers and pushes a packet summary.
// ----------------------------------------------------------------------------
module cprc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_data,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  logic [7:0]           pkt_byte,
	input  logic                 last_byte,
	input  logic                 len_mismatch,
	output logic                 rec_valid,
	input  logic                 rec_ready,
	output cprc_pkg::cprc_rec_t  rec
);

	localparam int PW = cprc_pkg::POSITION_BITS;
	localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

	logic [2:0]    link_type_q;
	logic [PW-1:0] pos_q;
	logic          link_ok_q;
	logic [31:0]   link_word_q;
	logic [3:0]    ihl_q;
	logic          ver_ok_q;
	logic [7:0]    proto_q;
	logic [15:0]   frag_q;
	logic [31:0]   src_q;
	logic [31:0]   dst_q;
	logic [15:0]   udp_len_q;
	logic [2:0]    magic_q;

	logic          link_ok_n;
	logic [31:0]   link_word_n;
	logic [3:0]    ihl_n;
	logic          ver_ok_n;
	logic [7:0]    proto_n;
	logic [15:0]   frag_n;
	logic [31:0]   src_n;
	logic [31:0]   dst_n;
	logic [15:0]   udp_len_n;
	logic [2:0]    magic_n;
	logic [PW-1:0] lpos;
	logic [PW-1:0] upos;
	logic [PW:0]   pos_inc;
	logic          accept;

	assign cfg_ready  = 1'b1;
	assign byte_ready = rec_ready;
	assign accept     = byte_valid && byte_ready;
	assign rec_valid  = accept && last_byte;

	assign lpos    = PW'(cprc_pkg::link_len(link_type_q));
	assign pos_inc = {1'b0, pos_q} + {{PW{1'b0}}, 1'b1};

	// per-byte header field capture
	always_comb begin
		link_word_n = {link_word_q[23:0], pkt_byte};
		link_ok_n   = link_ok_q;
		case (link_type_q)
			cprc_pkg::LINK_ETHERNET: begin
				if (pos_q == PW'(13) && link_word_n[15:0] == cprc_pkg::ETHERTYPE_IPV4)
					link_ok_n = 1'b1;
			end
			cprc_pkg::LINK_NULL: begin
				if (pos_q == PW'(3) && (link_word_n == 32'h0000_0002 ||
				    link_word_n == 32'h0200_0000))
					link_ok_n = 1'b1;
			end
			cprc_pkg::LINK_LOOP: begin
				if (pos_q == PW'(3) && link_word_n == 32'h0000_0002)
					link_ok_n = 1'b1;
			end
			cprc_pkg::LINK_COOKED1: begin
				if (pos_q == PW'(15) && link_word_n[15:0] == cprc_pkg::ETHERTYPE_IPV4)
					link_ok_n = 1'b1;
			end
			cprc_pkg::LINK_COOKED2: begin
				if (pos_q == PW'(1) && link_word_n[15:0] == cprc_pkg::ETHERTYPE_IPV4)
					link_ok_n = 1'b1;
			end
			cprc_pkg::LINK_RAW: link_ok_n = 1'b1;
			default: link_ok_n = link_ok_q;
		endcase

		ihl_n    = ihl_q;
		ver_ok_n = ver_ok_q;
		if (pos_q == lpos) begin
			ver_ok_n = pkt_byte[7:4] == 4'd4;
			ihl_n    = pkt_byte[3:0];
		end
		frag_n = frag_q;
		if (pos_q == lpos + PW'(6)) frag_n[15:8] = pkt_byte;
		if (pos_q == lpos + PW'(7)) frag_n[7:0] = pkt_byte;
		proto_n = proto_q;
		if (pos_q == lpos + PW'(9)) proto_n = pkt_byte;
		src_n = src_q;
		if (pos_q >= lpos + PW'(12) && pos_q < lpos + PW'(16))
			src_n = {src_q[23:0], pkt_byte};
		dst_n = dst_q;
		if (pos_q >= lpos + PW'(16) && pos_q < lpos + PW'(20))
			dst_n = {dst_q[23:0], pkt_byte};

		// udp length and magic, relative to the udp header start
		upos      = lpos + PW'({ihl_n, 2'b00});
		udp_len_n = udp_len_q;
		magic_n   = magic_q;
		if (pos_q > lpos) begin
			if (pos_q == upos + PW'(4)) udp_len_n[15:8] = pkt_byte;
			if (pos_q == upos + PW'(5)) udp_len_n[7:0] = pkt_byte;
			for (int k = 0; k < 4; k++) begin
				if (pos_q == upos + PW'(8 + k) && magic_q == 3'(k) &&
				    pkt_byte == cprc_pkg::RTPS_MAGIC[k])
					magic_n = 3'(k + 1);
			end
		end
	end

	// summary of the packet on its last beat
	always_comb begin
		rec.mismatch   = len_mismatch;
		rec.link_ok    = link_ok_n;
		rec.too_short  = pos_inc < ((PW+1)'(lpos) + (PW+1)'(cprc_pkg::IP_MIN_LEN));
		rec.ver_ok     = ver_ok_n;
		rec.proto      = proto_n;
		rec.frag       = frag_n;
		rec.src        = src_n;
		rec.dst        = dst_n;
		rec.offset     = 16'(cprc_pkg::link_len(link_type_q)) + 16'({ihl_n, 2'b00}) +
		                 16'(cprc_pkg::UDP_HDR_LEN);
		rec.udp_len    = udp_len_n;
		rec.magic_done = magic_n == 3'd4;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_type_q <= cprc_pkg::LINK_ETHERNET;
		end else if (cfg_valid && cfg_ready) begin
			link_type_q <= cfg_data;
		end
	end

	// per-packet state, cleared after the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			link_ok_q   <= 1'b0;
			link_word_q <= '0;
			ihl_q       <= '0;
			ver_ok_q    <= 1'b0;
			proto_q     <= '0;
			frag_q      <= '0;
			src_q       <= '0;
			dst_q       <= '0;
			udp_len_q   <= '0;
			magic_q     <= '0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q       <= '0;
				link_ok_q   <= 1'b0;
				link_word_q <= '0;
				ihl_q       <= '0;
				ver_ok_q    <= 1'b0;
				proto_q     <= '0;
				frag_q      <= '0;
				src_q       <= '0;
				dst_q       <= '0;
				udp_len_q   <= '0;
				magic_q     <= '0;
			end else begin
				if (pos_q != POS_MAX) pos_q <= pos_inc[PW-1:0];
				link_ok_q   <= link_ok_n;
				link_word_q <= link_word_n;
				ihl_q       <= ihl_n;
				ver_ok_q    <= ver_ok_n;
				proto_q     <= proto_n;
				frag_q      <= frag_n;
				src_q       <= src_n;
				dst_q       <= dst_n;
				udp_len_q   <= udp_len_n;
				magic_q     <= magic_n;
			end
		end
	end

endmodule

>>> src/cprc_queue.sv
// ----------------------------------------------------------------------------
// cprc_queue
// Small register queue of packet summaries between parser and result stage.
// ----------------------------------------------------------------------------
module cprc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  cprc_pkg::cprc_rec_t  wr_rec,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output cprc_pkg::cprc_rec_t  rd_rec
);

	localparam int DEPTH = cprc_pkg::QUEUE_DEPTH;
	localparam int PTRW  = cprc_pkg::QUEUE_PTR_W;
	localparam int CNTW  = cprc_pkg::QUEUE_CNT_W;

	cprc_pkg::cprc_rec_t slot_q [DEPTH];
	logic [PTRW-1:0]     wr_ptr_q;
	logic [PTRW-1:0]     rd_ptr_q;
	logic [CNTW-1:0]     count_q;
	logic                push;
	logic                pop;

	assign wr_ready = count_q != CNTW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_rec   = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_rec;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> src/cprc_back.sv
// ----------------------------------------------------------------------------
// cprc_back
// Result stage: forms the verdict, keeps packet counters, holds the output.
// ----------------------------------------------------------------------------
module cprc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rec_valid,
	output logic                 rec_ready,
	input  cprc_pkg::cprc_rec_t  rec,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [2:0]           verdict,
	output logic [31:0]          packet_number,
	output logic [31:0]          rtps_total,
	output logic [31:0]          source_address,
	output logic [31:0]          dest_address,
	output logic [15:0]          payload_offset,
	output logic [15:0]          payload_length
);

	localparam int CW = cprc_pkg::COUNT_BITS;

	logic          res_valid_q;
	logic [CW-1:0] pkt_cnt_q;
	logic [CW-1:0] rtps_cnt_q;
	logic [2:0]    verdict_q;
	logic [31:0]   pkt_num_q;
	logic [31:0]   rtps_tot_q;
	logic [31:0]   src_q;
	logic [31:0]   dst_q;
	logic [15:0]   offset_q;
	logic [15:0]   length_q;
	logic [2:0]    verdict_c;
	logic [CW-1:0] pkt_cnt_n;
	logic [CW-1:0] rtps_cnt_n;
	logic          pop;

	assign rec_ready = !res_valid_q || res_ready;
	assign pop       = rec_valid && rec_ready;

	// verdict priority
	always_comb begin
		if (rec.mismatch)
			verdict_c = cprc_pkg::VERDICT_LEN_MISM;
		else if (!rec.link_ok || rec.too_short || !rec.ver_ok)
			verdict_c = cprc_pkg::VERDICT_NOT_IPV4;
		else if (rec.proto != cprc_pkg::UDP_PROTO)
			verdict_c = cprc_pkg::VERDICT_NOT_UDP;
		else if ((rec.frag & (cprc_pkg::MORE_FRAGS | cprc_pkg::FRAG_OFFSET)) != '0)
			verdict_c = cprc_pkg::VERDICT_FRAG;
		else if (!rec.magic_done)
			verdict_c = cprc_pkg::VERDICT_NOT_RTPS;
		else
			verdict_c = cprc_pkg::VERDICT_RTPS;
		pkt_cnt_n  = pkt_cnt_q + 1'b1;
		rtps_cnt_n = (verdict_c == cprc_pkg::VERDICT_RTPS) ? rtps_cnt_q + 1'b1 : rtps_cnt_q;
	end

	// counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pkt_cnt_q   <= '0;
			rtps_cnt_q  <= '0;
		end else begin
			if (pop) begin
				res_valid_q <= 1'b1;
				pkt_cnt_q   <= pkt_cnt_n;
				rtps_cnt_q  <= rtps_cnt_n;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q  <= verdict_c;
			pkt_num_q  <= 32'(pkt_cnt_n);
			rtps_tot_q <= 32'(rtps_cnt_n);
			if (verdict_c == cprc_pkg::VERDICT_RTPS) begin
				src_q    <= rec.src;
				dst_q    <= rec.dst;
				offset_q <= rec.offset;
				length_q <= (rec.udp_len >= 16'(cprc_pkg::UDP_HDR_LEN)) ?
				            rec.udp_len - 16'(cprc_pkg::UDP_HDR_LEN) : 16'd0;
			end else begin
				src_q    <= '0;
				dst_q    <= '0;
				offset_q <= '0;
				length_q <= '0;
			end
		end
	end

	assign res_valid      = res_valid_q;
	assign verdict        = verdict_q;
	assign packet_number  = pkt_num_q;
	assign rtps_total     = rtps_tot_q;
	assign source_address = src_q;
	assign dest_address   = dst_q;
	assign payload_offset = offset_q;
	assign payload_length = length_q;

endmodule

>>> src/capture_packet_rtps_classifier.sv
// ----------------------------------------------------------------------------
// capture_packet_rtps_classifier
// Byte-serial IPv4/UDP/RTPS classifier for captured packets.
// ----------------------------------------------------------------------------
// Usage:
//   Packet bytes enter on the s_ channel, one byte per beat, with s_tlast on
//   the final byte and s_tuser carrying the length-mismatch flag on that beat.
//   One result beat per packet leaves on the m_ channel: verdict in m_tuser,
//   counters, addresses, payload offset and length in m_tdata.
//   link_type is written on the cfg channel while no packet is in flight;
//   a write takes effect from the next byte.
// Timing:
//   One byte is taken every cycle while the summary queue has room. The
//   result beat of a packet passes through the summary queue, then the
//   output register, after its last byte is taken. The byte parser updates
//   all header state as each byte is taken.
// Reset and stalls:
//   Reset clears link_type to ethernet, all header state and both counters.
//   When m_tready is low the result holds; the four-entry summary queue keeps
//   bytes flowing until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
module capture_packet_rtps_classifier (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_data,   // link_type
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,    // pkt_byte
	input  logic         s_tuser,    // len_mismatch
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata,    // packet_number, rtps_total, source_address,
	                                 // dest_address, payload_offset, payload_length
	output logic [2:0]   m_tuser     // verdict
);

	cprc_pkg::cprc_rec_t front_rec;
	cprc_pkg::cprc_rec_t back_rec;
	logic                front_valid;
	logic                front_ready;
	logic                back_valid;
	logic                back_ready;
	logic [31:0]         packet_number;
	logic [31:0]         rtps_total;
	logic [31:0]         source_address;
	logic [31:0]         dest_address;
	logic [15:0]         payload_offset;
	logic [15:0]         payload_length;

	// byte parser
	cprc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.byte_valid   (s_tvalid),
		.byte_ready   (s_tready),
		.pkt_byte     (s_tdata),
		.last_byte    (s_tlast),
		.len_mismatch (s_tuser),
		.rec_valid    (front_valid),
		.rec_ready    (front_ready),
		.rec          (front_rec)
	);

	// summary queue
	cprc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_rec   (front_rec),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_rec   (back_rec)
	);

	// result stage
	cprc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_valid      (back_valid),
		.rec_ready      (back_ready),
		.rec            (back_rec),
		.res_valid      (m_tvalid),
		.res_ready      (m_tready),
		.verdict        (m_tuser),
		.packet_number  (packet_number),
		.rtps_total     (rtps_total),
		.source_address (source_address),
		.dest_address   (dest_address),
		.payload_offset (payload_offset),
		.payload_length (payload_length)
	);

	// output beat packing
	assign m_tdata = {payload_length, payload_offset, dest_address, source_address,
	                  rtps_total, packet_number};

endmodule

>>> src/cprc_checker.sv
// ----------------------------------------------------------------------------
// cprc_checker
// Port-level checks on the result channel of the classifier.
// ----------------------------------------------------------------------------
module cprc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [159:0] m_tdata,
	input logic [2:0]   m_tuser
);

	// stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// non-rtps verdicts carry zero addresses, offset and length
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != cprc_pkg::VERDICT_RTPS |-> m_tdata[159:64] == '0)
		else $error("non-rtps result with nonzero address fields");

	// packet numbers of back-to-back result beats step by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) ##1 (m_tvalid && m_tready) |->
		m_tdata[31:0] == $past(m_tdata[31:0]) + 32'd1)
		else $error("packet number did not advance by one");

	// rtps total on back-to-back beats follows the verdict
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) ##1 (m_tvalid && m_tready) |->
		m_tdata[63:32] == $past(m_tdata[63:32]) +
		((m_tuser == cprc_pkg::VERDICT_RTPS) ? 32'd1 : 32'd0))
		else $error("rtps total inconsistent with verdict");

endmodule

bind capture_packet_rtps_classifier cprc_checker u_cprc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the capture packet RTPS classifier. Builds captured
// packets for every link type, well-formed and broken, streams them byte by
// byte under random source and sink stalls, and checks each verdict beat
// against a byte-serial header parser kept in the bench.
// ----------------------------------------------------------------------------
module testbench;

	// one packet byte as it travels on the slave side
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       mism;
	} pkt_beat_t;

	// one classification beat
	typedef struct packed {
		logic [2:0]  verdict;
		logic [31:0] pkt_num;
		logic [31:0] rtps_num;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] offset;
		logic [15:0] plen;
	} verdict_rec_t;

	// ways a generated packet can be broken
	typedef enum int {
		FLAW_NONE, FLAW_MISMATCH, FLAW_LINK, FLAW_VERSION, FLAW_PROTO, FLAW_MF,
		FLAW_OFFSET, FLAW_MAGIC, FLAW_SHORT_IP, FLAW_SHORT_UDP, FLAW_IHL_SMALL,
		FLAW_IHL_BIG, FLAW_NOISE
	} flaw_t;

	localparam int          POS_LIMIT = (1 << cprc_pkg::POSITION_BITS) - 1;
	// R T P S
	localparam logic [7:0]  RTPS_TAG [4] = '{8'h52, 8'h54, 8'h50, 8'h53};

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [159:0] m_tdata;
	logic [2:0]   m_tuser;

	pkt_beat_t    byte_queue [$];
	verdict_rec_t verdicts_due [$];
	int           error_count;
	int           send_idle_pct;
	int           recv_stall_pct;
	logic         null_swap_next;

	// parser state mirrored in the bench
	logic [2:0]   link_sel;
	logic [15:0]  pos_q;
	logic         link_seen;
	logic [31:0]  word_q;
	logic [3:0]   ihl_q;
	logic         ver_ok;
	logic [7:0]   proto_q;
	logic [15:0]  frag_q;
	logic [31:0]  src_q;
	logic [31:0]  dst_q;
	logic [15:0]  ulen_q;
	logic [2:0]   magic_q;
	logic [31:0]  pkt_cnt;
	logic [31:0]  rtps_cnt;

	capture_packet_rtps_classifier i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// link header size per link type
	function automatic int hdr_bytes(input logic [2:0] lt);
		case (lt)
			cprc_pkg::LINK_ETHERNET: return 14;
			cprc_pkg::LINK_NULL:     return 4;
			cprc_pkg::LINK_LOOP:     return 4;
			cprc_pkg::LINK_COOKED1:  return 16;
			cprc_pkg::LINK_COOKED2:  return 20;
			default:                 return 0;
		endcase
	endfunction

	task automatic clear_parse();
		pos_q = '0; link_seen = 1'b0; word_q = '0; ihl_q = '0; ver_ok = 1'b0;
		proto_q = '0; frag_q = '0; src_q = '0; dst_q = '0; ulen_q = '0;
		magic_q = '0;
	endtask

	// advance the header parser by one byte, queue a verdict on the last one
	task automatic classify_byte(input logic [7:0] b, input logic lst, input logic mm);
		int p;
		int hl;
		int u;
		verdict_rec_t r;
		p = pos_q;
		hl = hdr_bytes(link_sel);
		word_q = {word_q[23:0], b};
		case (link_sel)
			cprc_pkg::LINK_ETHERNET:
				if (p == 13 && word_q[15:0] == cprc_pkg::ETHERTYPE_IPV4) link_seen = 1'b1;
			cprc_pkg::LINK_NULL:
				if (p == 3 && (word_q == 32'h2 || word_q == 32'h02000000))
					link_seen = 1'b1;
			cprc_pkg::LINK_LOOP:
				if (p == 3 && word_q == 32'h2) link_seen = 1'b1;
			cprc_pkg::LINK_COOKED1:
				if (p == 15 && word_q[15:0] == cprc_pkg::ETHERTYPE_IPV4) link_seen = 1'b1;
			cprc_pkg::LINK_COOKED2:
				if (p == 1 && word_q[15:0] == cprc_pkg::ETHERTYPE_IPV4) link_seen = 1'b1;
			cprc_pkg::LINK_RAW: link_seen = 1'b1;
			default: ;
		endcase
		// fixed ipv4 header fields
		if (p == hl) begin
			ver_ok = (b[7:4] == 4'd4);
			ihl_q = b[3:0];
		end
		if (p == hl + 6) frag_q[15:8] = b;
		if (p == hl + 7) frag_q[7:0] = b;
		if (p == hl + 9) proto_q = b;
		if (p >= hl + 12 && p < hl + 16) src_q = {src_q[23:0], b};
		if (p >= hl + 16 && p < hl + 20) dst_q = {dst_q[23:0], b};
		// udp length and magic, placed by the header length
		u = hl + ihl_q * 4;
		if (p > hl) begin
			if (p == u + 4) ulen_q[15:8] = b;
			if (p == u + 5) ulen_q[7:0] = b;
			if (p >= u + 8 && p < u + 12 && magic_q == p - u - 8 && b == RTPS_TAG[p - u - 8])
				magic_q = magic_q + 3'd1;
		end
		if (p < POS_LIMIT) pos_q = 16'(p + 1);
		if (lst) begin
			pkt_cnt = pkt_cnt + 32'd1;
			if (mm) r.verdict = cprc_pkg::VERDICT_LEN_MISM;
			else if (!link_seen || p + 1 < hl + cprc_pkg::IP_MIN_LEN || !ver_ok)
				r.verdict = cprc_pkg::VERDICT_NOT_IPV4;
			else if (proto_q != cprc_pkg::UDP_PROTO) r.verdict = cprc_pkg::VERDICT_NOT_UDP;
			else if ((frag_q & (cprc_pkg::MORE_FRAGS | cprc_pkg::FRAG_OFFSET)) != 16'd0)
				r.verdict = cprc_pkg::VERDICT_FRAG;
			else if (magic_q != 3'd4) r.verdict = cprc_pkg::VERDICT_NOT_RTPS;
			else r.verdict = cprc_pkg::VERDICT_RTPS;
			r.pkt_num = pkt_cnt;
			if (r.verdict == cprc_pkg::VERDICT_RTPS) begin
				rtps_cnt = rtps_cnt + 32'd1;
				r.src = src_q;
				r.dst = dst_q;
				r.offset = 16'(u + 8);
				r.plen = (ulen_q >= 16'd8) ? ulen_q - 16'd8 : 16'd0;
			end else begin
				r.src = '0; r.dst = '0; r.offset = '0; r.plen = '0;
			end
			r.rtps_num = rtps_cnt;
			verdicts_due.push_back(r);
			clear_parse();
		end
	endtask

	// build one packet for the current link type and queue its bytes
	task automatic queue_packet(input flaw_t flaw, input int extra);
		logic [7:0]  frame [$];
		logic [3:0]  ihl;
		logic [3:0]  ver;
		logic [12:0] foff;
		logic [15:0] ulen;
		pkt_beat_t   beat;
		int          hl;
		int          u;
		int          pay;
		int          total;
		int          k;
		hl = hdr_bytes(link_sel);
		ihl = 4'd5;
		if (flaw == FLAW_IHL_SMALL) ihl = 4'($urandom_range(0, 4));
		else if (flaw == FLAW_IHL_BIG) ihl = 4'($urandom_range(6, 15));
		u = hl + ihl * 4;
		pay = $urandom_range(0, 12) + extra;
		total = ((hl + 20 > u + 12) ? hl + 20 : u + 12) + pay;
		for (int i = 0; i < total; i++) frame.push_back(8'($urandom_range(0, 255)));

		// link header
		case (link_sel)
			cprc_pkg::LINK_ETHERNET: begin frame[12] = 8'h08; frame[13] = 8'h00; end
			cprc_pkg::LINK_NULL: begin
				frame[0] = null_swap_next ? 8'h02 : 8'h00;
				frame[1] = 8'h00; frame[2] = 8'h00;
				frame[3] = null_swap_next ? 8'h00 : 8'h02;
				null_swap_next = !null_swap_next;
			end
			cprc_pkg::LINK_LOOP: begin
				frame[0] = 8'h00; frame[1] = 8'h00; frame[2] = 8'h00; frame[3] = 8'h02;
			end
			cprc_pkg::LINK_COOKED1: begin frame[14] = 8'h08; frame[15] = 8'h00; end
			cprc_pkg::LINK_COOKED2: begin frame[0] = 8'h08; frame[1] = 8'h00; end
			default: ;
		endcase
		if (flaw == FLAW_LINK) begin
			// loop may get the rejected swapped family order; other link headers get a bad byte
			if (link_sel == cprc_pkg::LINK_LOOP && $urandom_range(0, 1)) begin
				frame[0] = 8'h02; frame[3] = 8'h00;
			end else if (hl > 0) begin
				k = (link_sel == cprc_pkg::LINK_ETHERNET) ? $urandom_range(12, 13) :
				    (link_sel == cprc_pkg::LINK_COOKED1)  ? $urandom_range(14, 15) :
				    (link_sel == cprc_pkg::LINK_COOKED2)  ? $urandom_range(0, 1) :
				    $urandom_range(0, 3);
				frame[k] = frame[k] ^ 8'($urandom_range(1, 255));
			end
		end

		// ipv4 header
		ver = 4'd4;
		if (flaw == FLAW_VERSION) begin
			ver = 4'($urandom_range(0, 14));
			if (ver >= 4'd4) ver = ver + 4'd1;
		end
		frame[hl] = {ver, ihl};
		frame[hl + 6] = 8'($urandom_range(0, 3)) << 6;
		frame[hl + 7] = 8'h00;
		if (flaw == FLAW_MF) frame[hl + 6] = frame[hl + 6] | 8'h20;
		if (flaw == FLAW_OFFSET) begin
			foff = 13'($urandom_range(1, 8191));
			frame[hl + 6] = frame[hl + 6] | {3'b000, foff[12:8]};
			frame[hl + 7] = foff[7:0];
		end
		frame[hl + 9] = cprc_pkg::UDP_PROTO;
		if (flaw == FLAW_PROTO) begin
			frame[hl + 9] = 8'($urandom_range(0, 254));
			if (frame[hl + 9] >= cprc_pkg::UDP_PROTO) frame[hl + 9] = frame[hl + 9] + 8'd1;
		end

		// udp length, then the magic
		case ($urandom_range(0, 3))
			0: ulen = 16'(pay + 12);
			1: ulen = 16'($urandom_range(0, 7));
			2: ulen = $urandom_range(0, 1) ? 16'hFFFF : 16'd8;
			default: ulen = 16'($urandom_range(0, 65535));
		endcase
		frame[u + 4] = ulen[15:8];
		frame[u + 5] = ulen[7:0];
		for (int i = 0; i < 4; i++) frame[u + 8 + i] = RTPS_TAG[i];
		if (flaw == FLAW_MAGIC) begin
			k = u + 8 + $urandom_range(0, 3);
			frame[k] = frame[k] ^ 8'($urandom_range(1, 255));
		end

		// truncation and pure noise
		k = frame.size();
		if (flaw == FLAW_SHORT_IP) k = $urandom_range(1, hl + 19);
		if (flaw == FLAW_SHORT_UDP) k = $urandom_range(hl + 20, u + 11);
		while (frame.size() > k) void'(frame.pop_back());
		if (flaw == FLAW_NOISE) begin
			frame.delete();
			k = $urandom_range(1, 40);
			for (int i = 0; i < k; i++) frame.push_back(8'($urandom_range(0, 255)));
		end

		foreach (frame[i]) begin
			beat.data = frame[i];
			beat.last = (i == frame.size() - 1);
			beat.mism = beat.last ? (flaw == FLAW_MISMATCH) : 1'($urandom_range(0, 1));
			byte_queue.push_back(beat);
		end
	endtask

	task automatic write_link_type(input logic [2:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		link_sel = v;
	endtask

	// wait until every byte is taken and every verdict is back
	task automatic wait_quiet();
		do begin
			while (byte_queue.size() != 0 || s_tvalid || verdicts_due.size() != 0)
				@(posedge clk);
			repeat (8) @(posedge clk);
		end while (byte_queue.size() != 0 || s_tvalid || verdicts_due.size() != 0);
	endtask

	task automatic set_pace(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
			default: begin send_idle_pct = 20; recv_stall_pct = 20; end
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// byte source
	always @(posedge clk) begin : drive_bytes
		pkt_beat_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = byte_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nxt.data;
				s_tlast <= nxt.last;
				s_tuser <= nxt.mism;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result sink
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// watch both sides: predict on accepted bytes, check accepted verdicts
	always @(posedge clk) begin : watch_beats
		verdict_rec_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) classify_byte(s_tdata, s_tlast, s_tuser);
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					$error("verdict beat with none pending: verdict %0d", m_tuser);
					error_count++;
				end else begin
					want = verdicts_due.pop_front();
					check_field("verdict", want.verdict, m_tuser);
					check_field("packet_number", want.pkt_num, m_tdata[31:0]);
					check_field("rtps_total", want.rtps_num, m_tdata[63:32]);
					check_field("source_address", want.src, m_tdata[95:64]);
					check_field("dest_address", want.dst, m_tdata[127:96]);
					check_field("payload_offset", want.offset, m_tdata[143:128]);
					check_field("payload_length", want.plen, m_tdata[159:144]);
				end
			end
		end
	end

	// watchdog
	initial begin
		#2400000;
		$display("tb: failure");
		$finish;
	end

	// stimulus phases
	initial begin : stimulus
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		error_count = 0;
		null_swap_next = 1'b0;
		link_sel = cprc_pkg::LINK_ETHERNET;
		pkt_cnt = '0;
		rtps_cnt = '0;
		clear_parse();
		set_pace(0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every flaw on ethernet with no idling
		write_link_type(cprc_pkg::LINK_ETHERNET);
		for (int f = FLAW_NONE; f <= FLAW_NOISE; f++) queue_packet(flaw_t'(f), 0);
		wait_quiet();
		// good and broken link headers on the other link types, pace cycling
		for (int lt = 1; lt < 8; lt++) begin
			set_pace(lt % 4);
			write_link_type(3'(lt));
			queue_packet(FLAW_NONE, 0);
			queue_packet(FLAW_LINK, 0);
			wait_quiet();
		end

		if (error_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
src/cprc_pkg.sv
src/cprc_front.sv
src/cprc_queue.sv
src/cprc_back.sv
src/capture_packet_rtps_classifier.sv
src/cprc_checker.sv
tb/testbench.sv
